>>> hdl/breakpoint_match_table_top_defines.svh
// Assertion macros shared by the breakpoint table RTL.
`ifndef BREAKPOINT_MATCH_TABLE_TOP_DEFINES_SVH
`define BREAKPOINT_MATCH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BMT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("breakpoint table check failed");

// Next-cycle implication, checked out of reset.
`define BMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("breakpoint table sequencing failed");

`endif

>>> hdl/bmt_pkg.sv
`default_nettype none
package bmt_pkg;

    localparam int ENTRIES = 8;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W  = 24;
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 3;
    localparam int TIME_W  = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 96;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET,
        CMD_DELETE,
        CMD_CHECK,
        CMD_HIT,
        CMD_ENABLE,
        CMD_CLEAR,
        CMD_READDR,
        CMD_READ
    } cmd_t;

    typedef enum logic [2:0] {
        WR_NEW,
        WR_ENABLE,
        WR_FREE,
        WR_HIT,
        WR_CLEAR,
        WR_ADDR
    } wr_op_t;

    // Search token that walks down the row of cells.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic              loose;
        logic              match_found;
        logic [SLOT_W-1:0] match_slot;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              qual_found;
        logic [SLOT_W-1:0] qual_slot;
    } scan_t;

    // Update broadcast to all cells; only the addressed one acts.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        wr_op_t            op;
        logic [ADDR_W-1:0] address;
        logic              enable;
        logic [TIME_W-1:0] stamp;
    } wr_t;

    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] address;
        logic              enabled;
        logic [TIME_W-1:0] hits;
        logic [TIME_W-1:0] stamp;
    } slot_t;

endpackage
`default_nettype wire

>>> hdl/bmt_cell.sv
`default_nettype none
module bmt_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [bmt_pkg::SLOT_W-1:0] cell_index,
    input  wire bmt_pkg::scan_t             scan_in,
    output bmt_pkg::scan_t                  scan_out,
    input  wire bmt_pkg::wr_t               wr,
    output bmt_pkg::slot_t                  slot
);

    bmt_pkg::scan_t scan_reg;
    bmt_pkg::scan_t scan_next;
    bmt_pkg::slot_t slot_reg;
    bmt_pkg::slot_t slot_next;
    logic           addr_hit;
    logic           wr_sel;

    assign addr_hit = slot_reg.used && (slot_reg.address == scan_in.address);
    assign wr_sel   = wr.valid && (wr.slot == cell_index);

    // Lower cells already claimed a slot: keep theirs, else claim this one.
    always_comb
    begin
        scan_next = scan_in;
        if (addr_hit && !scan_in.match_found)
        begin
            scan_next.match_found = 1'b1;
            scan_next.match_slot  = cell_index;
        end
        if (!slot_reg.used && !scan_in.free_found)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_slot  = cell_index;
        end
        if (addr_hit && (scan_in.loose || slot_reg.enabled) && !scan_in.qual_found)
        begin
            scan_next.qual_found = 1'b1;
            scan_next.qual_slot  = cell_index;
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (wr_sel)
        begin
            case (wr.op)
                bmt_pkg::WR_NEW:
                begin
                    slot_next.used    = 1'b1;
                    slot_next.address = wr.address;
                    slot_next.enabled = wr.enable;
                    slot_next.hits    = '0;
                    slot_next.stamp   = '0;
                end
                bmt_pkg::WR_ENABLE:
                begin
                    if (slot_reg.used)
                    begin
                        slot_next.enabled = wr.enable;
                    end
                end
                bmt_pkg::WR_FREE:
                begin
                    slot_next.used = 1'b0;
                end
                bmt_pkg::WR_HIT:
                begin
                    slot_next.stamp = wr.stamp;
                    slot_next.hits  = slot_reg.hits + bmt_pkg::TIME_W'(1);
                end
                bmt_pkg::WR_CLEAR:
                begin
                    if (slot_reg.used)
                    begin
                        slot_next.hits  = '0;
                        slot_next.stamp = '0;
                    end
                end
                bmt_pkg::WR_ADDR:
                begin
                    if (slot_reg.used)
                    begin
                        slot_next.address = wr.address;
                    end
                end
                default:
                begin
                    slot_next = slot_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            slot_reg <= slot_next;
        end
    end

    assign scan_out = scan_reg;
    assign slot     = slot_reg;

endmodule
`default_nettype wire

>>> hdl/breakpoint_match_table_top.sv
// Each command runs a search token down a row of ENTRIES cells, one cell per cycle.
// Path: the cell registers, then S_APPLY, then S_FINISH, then the output register.
// A new command is taken only in S_IDLE, once the last one has left S_FINISH.
// Input is taken again while a result waits; a new result waits for the output register.
// Reset: asynchronous, active low; clears every slot and the checking flag, drops the output.
`default_nettype none
module breakpoint_match_table_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // command[2:0], address[26:3], enable_flag[27], match_disabled_too[28],
    // entry_index[31:29], timestamp[63:32]
    input  wire logic [bmt_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // found[0], match_index[3:1], table_full[4], entry_used[5], entry_address[29:6],
    // entry_enabled[30], entry_hits[62:31], entry_time[94:63], any_enabled[95]
    output logic [bmt_pkg::OUT_W-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    bmt_pkg::cmd_t                   cmd_reg, cmd_next;
    logic                            en_flag_reg, en_flag_next;
    logic [bmt_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [bmt_pkg::TIME_W-1:0]      time_reg, time_next;
    bmt_pkg::wr_t                    wr_reg, wr_next;
    logic                            found_reg, found_next;
    logic [bmt_pkg::IDX_W-1:0]       mindex_reg, mindex_next;
    logic                            full_reg, full_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bmt_pkg::OUT_W-1:0]       out_data_reg, out_data_next;

    bmt_pkg::scan_t                  scan_head;
    bmt_pkg::scan_t                  chain [bmt_pkg::ENTRIES+1];
    bmt_pkg::slot_t                  slots [bmt_pkg::ENTRIES];
    bmt_pkg::scan_t                  scan_end;
    bmt_pkg::slot_t                  rd_slot;
    logic [bmt_pkg::ENTRIES-1:0]     live_en;
    logic                            any_en;
    logic                            idx_ok;
    logic                            in_beat;
    logic [bmt_pkg::SLOT_W-1:0]      idx_slot;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        scan_head         = '0;
        scan_head.valid   = in_beat;
        scan_head.address = s_tdata[26:3];
        scan_head.loose   = s_tdata[28];
    end

    assign chain[0] = scan_head;

    genvar g;
    generate
        for (g = 0; g < bmt_pkg::ENTRIES; g++)
        begin : g_cell
            bmt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (bmt_pkg::SLOT_W'(g)),
                .scan_in    (chain[g]),
                .scan_out   (chain[g+1]),
                .wr         (wr_reg),
                .slot       (slots[g])
            );
            assign live_en[g] = slots[g].used && slots[g].enabled;
        end
    endgenerate

    assign scan_end = chain[bmt_pkg::ENTRIES];
    assign any_en   = |live_en;
    assign idx_ok   = (32'(idx_reg) < bmt_pkg::ENTRIES);
    assign idx_slot = bmt_pkg::SLOT_W'(idx_reg);
    assign rd_slot  = slots[idx_slot];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        en_flag_next   = en_flag_reg;
        idx_next       = idx_reg;
        time_next      = time_reg;
        wr_next        = wr_reg;
        found_next     = found_reg;
        mindex_next    = mindex_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next     = bmt_pkg::cmd_t'(s_tdata[2:0]);
                    en_flag_next = s_tdata[27];
                    idx_next     = s_tdata[31:29];
                    time_next    = s_tdata[63:32];
                    found_next   = 1'b0;
                    mindex_next  = '0;
                    full_next    = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end.valid)
                begin
                    wr_next         = '0;
                    wr_next.address = scan_end.address;
                    wr_next.enable  = en_flag_reg;
                    wr_next.stamp   = time_reg;
                    case (cmd_reg)
                        bmt_pkg::CMD_SET:
                        begin
                            if (scan_end.match_found)
                            begin
                                wr_next.valid = 1'b1;
                                wr_next.slot  = scan_end.match_slot;
                                wr_next.op    = bmt_pkg::WR_ENABLE;
                            end
                            else if (scan_end.free_found)
                            begin
                                wr_next.valid = 1'b1;
                                wr_next.slot  = scan_end.free_slot;
                                wr_next.op    = bmt_pkg::WR_NEW;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        bmt_pkg::CMD_DELETE:
                        begin
                            wr_next.valid = scan_end.match_found;
                            wr_next.slot  = scan_end.match_slot;
                            wr_next.op    = bmt_pkg::WR_FREE;
                        end
                        bmt_pkg::CMD_CHECK:
                        begin
                            if (scan_end.qual_found && any_en)
                            begin
                                found_next  = 1'b1;
                                mindex_next = bmt_pkg::IDX_W'(scan_end.qual_slot);
                            end
                        end
                        bmt_pkg::CMD_HIT:
                        begin
                            wr_next.valid = scan_end.match_found;
                            wr_next.slot  = scan_end.match_slot;
                            wr_next.op    = bmt_pkg::WR_HIT;
                        end
                        bmt_pkg::CMD_ENABLE:
                        begin
                            wr_next.valid = idx_ok;
                            wr_next.slot  = idx_slot;
                            wr_next.op    = bmt_pkg::WR_ENABLE;
                        end
                        bmt_pkg::CMD_CLEAR:
                        begin
                            wr_next.valid = idx_ok;
                            wr_next.slot  = idx_slot;
                            wr_next.op    = bmt_pkg::WR_CLEAR;
                        end
                        bmt_pkg::CMD_READDR:
                        begin
                            wr_next.valid = idx_ok;
                            wr_next.slot  = idx_slot;
                            wr_next.op    = bmt_pkg::WR_ADDR;
                        end
                        default:
                        begin
                            wr_next.valid = 1'b0;
                        end
                    endcase
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // cells take the update at this edge
                wr_next.valid = 1'b0;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[0]   = found_reg;
                    out_data_next[3:1] = mindex_reg;
                    out_data_next[4]   = full_reg;
                    if ((cmd_reg == bmt_pkg::CMD_READ) && idx_ok)
                    begin
                        out_data_next[5]     = rd_slot.used;
                        out_data_next[29:6]  = rd_slot.address;
                        out_data_next[30]    = rd_slot.enabled;
                        out_data_next[62:31] = rd_slot.hits;
                        out_data_next[94:63] = rd_slot.stamp;
                    end
                    out_data_next[95] = any_en;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= bmt_pkg::CMD_SET;
            en_flag_reg   <= 1'b0;
            idx_reg       <= '0;
            time_reg      <= '0;
            wr_reg        <= '0;
            found_reg     <= 1'b0;
            mindex_reg    <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            en_flag_reg   <= en_flag_next;
            idx_reg       <= idx_next;
            time_reg      <= time_next;
            wr_reg        <= wr_next;
            found_reg     <= found_next;
            mindex_reg    <= mindex_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

`include "breakpoint_match_table_top_defines.svh"

    `BMT_ASSERT_NEXT(a_accept_starts_scan, in_beat, state_reg == S_SCAN)
    `BMT_ASSERT_SAME(a_token_only_in_scan, scan_end.valid, state_reg == S_SCAN)
    `BMT_ASSERT_SAME(a_update_only_in_apply, wr_reg.valid, state_reg == S_APPLY)
    `BMT_ASSERT_SAME(a_found_full_exclusive, out_valid_reg, !(out_data_reg[0] && out_data_reg[4]))

endmodule
`default_nettype wire

>>> sim/tb_breakpoint_match_table_top.sv
`default_nettype none
module tb_breakpoint_match_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 2 * (bmt_pkg::ENTRIES + 3);
    localparam int POOL_SIZE = 10;

    // Field order is MSB first, so command lands in the low bits of tdata.
    typedef struct packed {
        logic [bmt_pkg::TIME_W-1:0] timestamp;
        logic [bmt_pkg::IDX_W-1:0]  entry_index;
        logic                       match_disabled_too;
        logic                       enable_flag;
        logic [bmt_pkg::ADDR_W-1:0] address;
        bmt_pkg::cmd_t              command;
    } bp_cmd_t;

    typedef struct packed {
        logic                       any_enabled;
        logic [bmt_pkg::TIME_W-1:0] entry_time;
        logic [bmt_pkg::TIME_W-1:0] entry_hits;
        logic                       entry_enabled;
        logic [bmt_pkg::ADDR_W-1:0] entry_address;
        logic                       entry_used;
        logic                       table_full;
        logic [bmt_pkg::SLOT_W-1:0] match_index;
        logic                       found;
    } bp_result_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [bmt_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [bmt_pkg::OUT_W-1:0] m_tdata;

    // Predicted breakpoint table
    logic                       bp_used [bmt_pkg::ENTRIES];
    logic [bmt_pkg::ADDR_W-1:0] bp_addr [bmt_pkg::ENTRIES];
    logic                       bp_en   [bmt_pkg::ENTRIES];
    logic [bmt_pkg::TIME_W-1:0] bp_hits [bmt_pkg::ENTRIES];
    logic [bmt_pkg::TIME_W-1:0] bp_time [bmt_pkg::ENTRIES];
    logic                       bp_armed;

    bp_result_t pending_results [$];
    logic [bmt_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    int errors = 0;
    int cycles;
    bit src_idle_on = 1'b0;
    bit sink_idle_on = 1'b0;
    int sink_hold_req = 0;
    int sink_hold_left = 0;
    int sink_burst_left = 0;

    breakpoint_match_table_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int lowest_match(input logic [bmt_pkg::ADDR_W-1:0] address);
        int slot;
        int i;
        slot = -1;
        for (i = bmt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (bp_used[i] && bp_addr[i] == address)
                slot = i;
        end
        return slot;
    endfunction

    function automatic bp_result_t apply_command(input bp_cmd_t c);
        bp_result_t r;
        int slot;
        int i;
        logic idx_ok;
        r = '0;
        slot = lowest_match(c.address);
        idx_ok = (c.entry_index < bmt_pkg::ENTRIES);
        case (c.command)
            bmt_pkg::CMD_SET:
            begin
                if (slot >= 0)
                    bp_en[slot] = c.enable_flag;
                else
                begin
                    for (i = bmt_pkg::ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!bp_used[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        bp_used[slot] = 1'b1;
                        bp_addr[slot] = c.address;
                        bp_en[slot]   = c.enable_flag;
                        bp_hits[slot] = '0;
                        bp_time[slot] = '0;
                    end
                    else
                        r.table_full = 1'b1;
                end
            end
            bmt_pkg::CMD_DELETE:
            begin
                if (slot >= 0)
                    bp_used[slot] = 1'b0;
            end
            bmt_pkg::CMD_CHECK:
            begin
                if (bp_armed)
                begin
                    for (i = 0; i < bmt_pkg::ENTRIES; i++)
                    begin
                        if (!r.found && bp_used[i] && bp_addr[i] == c.address &&
                            (c.match_disabled_too || bp_en[i]))
                        begin
                            r.found = 1'b1;
                            r.match_index = bmt_pkg::SLOT_W'(i);
                        end
                    end
                end
            end
            bmt_pkg::CMD_HIT:
            begin
                if (slot >= 0)
                begin
                    bp_time[slot] = c.timestamp;
                    bp_hits[slot] = bp_hits[slot] + bmt_pkg::TIME_W'(1);
                end
            end
            bmt_pkg::CMD_ENABLE:
            begin
                if (idx_ok && bp_used[c.entry_index])
                    bp_en[c.entry_index] = c.enable_flag;
            end
            bmt_pkg::CMD_CLEAR:
            begin
                if (idx_ok && bp_used[c.entry_index])
                begin
                    bp_hits[c.entry_index] = '0;
                    bp_time[c.entry_index] = '0;
                end
            end
            bmt_pkg::CMD_READDR:
            begin
                if (idx_ok && bp_used[c.entry_index])
                    bp_addr[c.entry_index] = c.address;
            end
            default:
            begin
                if (idx_ok)
                begin
                    r.entry_used    = bp_used[c.entry_index];
                    r.entry_address = bp_addr[c.entry_index];
                    r.entry_enabled = bp_en[c.entry_index];
                    r.entry_hits    = bp_hits[c.entry_index];
                    r.entry_time    = bp_time[c.entry_index];
                end
            end
        endcase
        bp_armed = 1'b0;
        for (i = 0; i < bmt_pkg::ENTRIES; i++)
        begin
            if (bp_used[i] && bp_en[i])
                bp_armed = 1'b1;
        end
        r.any_enabled = bp_armed;
        return r;
    endfunction

    // Call just after a rising edge; returns after the beat is taken and any idle gap.
    task automatic issue_command(input bmt_pkg::cmd_t cmd,
                                 input logic [bmt_pkg::ADDR_W-1:0] address,
                                 input logic enable_flag, input logic loose,
                                 input logic [bmt_pkg::IDX_W-1:0] index,
                                 input logic [bmt_pkg::TIME_W-1:0] stamp);
        bp_cmd_t beat;
        beat.command            = cmd;
        beat.address            = address;
        beat.enable_flag        = enable_flag;
        beat.match_disabled_too = loose;
        beat.entry_index        = index;
        beat.timestamp          = stamp;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_command(beat));
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [bmt_pkg::ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 3) != 0)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return bmt_pkg::ADDR_W'($urandom);
    endfunction

    task automatic issue_random_command();
        int roll;
        bmt_pkg::cmd_t cmd;
        roll = $urandom_range(0, 99);
        if (roll < 22)
            cmd = bmt_pkg::CMD_SET;
        else if (roll < 34)
            cmd = bmt_pkg::CMD_DELETE;
        else if (roll < 59)
            cmd = bmt_pkg::CMD_CHECK;
        else if (roll < 74)
            cmd = bmt_pkg::CMD_HIT;
        else if (roll < 80)
            cmd = bmt_pkg::CMD_ENABLE;
        else if (roll < 85)
            cmd = bmt_pkg::CMD_CLEAR;
        else if (roll < 90)
            cmd = bmt_pkg::CMD_READDR;
        else
            cmd = bmt_pkg::CMD_READ;
        issue_command(cmd, pick_address(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)),
                      bmt_pkg::IDX_W'($urandom_range(0, (1 << bmt_pkg::IDX_W) - 1)),
                      $urandom);
    endtask

    task automatic check_result(input bp_result_t got);
        bp_result_t want;
        if (pending_results.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat: %h", got);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.found !== want.found || got.match_index !== want.match_index ||
                got.table_full !== want.table_full ||
                got.entry_used !== want.entry_used ||
                got.entry_address !== want.entry_address ||
                got.entry_enabled !== want.entry_enabled ||
                got.entry_hits !== want.entry_hits ||
                got.entry_time !== want.entry_time ||
                got.any_enabled !== want.any_enabled)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result mismatch (expected/actual): found %b/%b idx %0d/%0d",
                             want.found, got.found, want.match_index, got.match_index);
                    $display("  full %b/%b used %b/%b addr %h/%h en %b/%b",
                             want.table_full, got.table_full,
                             want.entry_used, got.entry_used,
                             want.entry_address, got.entry_address,
                             want.entry_enabled, got.entry_enabled);
                    $display("  hits %h/%h time %h/%h any %b/%b",
                             want.entry_hits, got.entry_hits,
                             want.entry_time, got.entry_time,
                             want.any_enabled, got.any_enabled);
                end
            end
        end
    endtask

    // Result side: check each beat, then choose next cycle's ready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(bp_result_t'(m_tdata));
        if (sink_hold_req != 0)
        begin
            sink_hold_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_hold_left > 0)
        begin
            sink_hold_left--;
            m_tready <= 1'b0;
        end
        else if (sink_burst_left > 0)
        begin
            sink_burst_left--;
            m_tready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_burst_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
            @(posedge clk);
        $display("breakpoint_match_table_top regression: fail");
        $finish;
    end

    task automatic test_empty_table();
        // Checking is off, so even a loose check finds nothing.
        issue_command(bmt_pkg::CMD_CHECK, 24'h000000, 1'b0, 1'b1, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_HIT, 24'h000000, 1'b1, 1'b0, 3'd0, $urandom);
    endtask

    task automatic test_set_and_hit();
        issue_command(bmt_pkg::CMD_SET, 24'hFFFFFF, 1'b0, 1'b0, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_CHECK, 24'hFFFFFF, 1'b0, 1'b1, 3'd0, $urandom);
        // Hit stamps a disabled entry too.
        issue_command(bmt_pkg::CMD_HIT, 24'hFFFFFF, 1'b0, 1'b0, 3'd0, 32'hFFFFFFFF);
        issue_command(bmt_pkg::CMD_READ, 24'h000000, 1'b0, 1'b0, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_SET, 24'h000000, 1'b1, 1'b0, 3'd7, $urandom);
        issue_command(bmt_pkg::CMD_CHECK, 24'hFFFFFF, 1'b1, 1'b0, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_CHECK, 24'hFFFFFF, 1'b0, 1'b1, 3'd0, $urandom);
        // Existing address: only the enable changes.
        issue_command(bmt_pkg::CMD_SET, 24'hFFFFFF, 1'b1, 1'b0, 3'd0, $urandom);
    endtask

    task automatic test_delete_and_free_slot();
        issue_command(bmt_pkg::CMD_DELETE, 24'hABCDEF, 1'b0, 1'b0, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_DELETE, 24'hFFFFFF, 1'b0, 1'b0, 3'd0, $urandom);
        // Index commands on a freed entry do nothing; read still shows old contents.
        issue_command(bmt_pkg::CMD_ENABLE, 24'h000000, 1'b1, 1'b0, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_READDR, 24'h555555, 1'b0, 1'b0, 3'd0, $urandom);
        issue_command(bmt_pkg::CMD_READ, 24'h000000, 1'b0, 1'b0, 3'd0, $urandom);
    endtask

    task automatic test_index_ops();
        issue_command(bmt_pkg::CMD_ENABLE, 24'h000000, 1'b0, 1'b0, 3'd1, $urandom);
        issue_command(bmt_pkg::CMD_HIT, 24'h000000, 1'b0, 1'b0, 3'd1, 32'h00000000);
        issue_command(bmt_pkg::CMD_CLEAR, 24'h000000, 1'b0, 1'b0, 3'd1, $urandom);
        issue_command(bmt_pkg::CMD_READ, 24'h000000, 1'b0, 1'b0, 3'd1, $urandom);
    endtask

    task automatic test_full_table();
        int i;
        for (i = 0; i < bmt_pkg::ENTRIES - 1; i++)
            issue_command(bmt_pkg::CMD_SET, bmt_pkg::ADDR_W'(24'h100000 + i), 1'b1, 1'b0,
                          3'd0, $urandom);
        issue_command(bmt_pkg::CMD_SET, 24'hABCDEF, 1'b1, 1'b0, 3'd0, $urandom);
        // Readdress onto an address already in use: the lower entry wins.
        issue_command(bmt_pkg::CMD_READDR, 24'h000000, 1'b0, 1'b0,
                      bmt_pkg::IDX_W'(bmt_pkg::ENTRIES - 1), $urandom);
        issue_command(bmt_pkg::CMD_CHECK, 24'h000000, 1'b0, 1'b1, 3'd0, $urandom);
    endtask

    task automatic test_output_backpressure();
        int i;
        src_idle_on = 1'b0;
        sink_hold_req = 300;
        for (i = 0; i < 12; i++)
            issue_random_command();
        drain_results();
    endtask

    task automatic test_random_mix(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                src_idle_on = (n < count - 120) && ($urandom_range(0, 3) != 0);
                sink_idle_on = (n < count - 120) && ($urandom_range(0, 3) != 0);
            end
            issue_random_command();
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < bmt_pkg::ENTRIES; i++)
        begin
            bp_used[i] = 1'b0;
            bp_addr[i] = '0;
            bp_en[i]   = 1'b0;
            bp_hits[i] = '0;
            bp_time[i] = '0;
        end
        bp_armed = 1'b0;
        addr_pool[0] = 24'h000000;
        addr_pool[1] = 24'hFFFFFF;
        for (i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = bmt_pkg::ADDR_W'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        test_empty_table();
        test_set_and_hit();
        test_delete_and_free_slot();
        test_index_ops();
        test_full_table();
        test_output_backpressure();
        test_random_mix(510);

        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        errors += pending_results.size();
        if (errors == 0)
            $display("breakpoint_match_table_top regression: pass");
        else
            $display("breakpoint_match_table_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
